// File: hw/rtl/tsp1t_pkg.sv
// ----------------------------------------------------------------------------
// tsp1t_pkg: shared types and constants of the 1-tree lower bound block
// Holds default sizes, action codes, sweep kinds and the controller/datapath
// command and status records.
// ----------------------------------------------------------------------------
package tsp1t_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int DIST_BITS_DEF = 16;

	localparam int ACTION_W   = 2;
	localparam int ROW_W      = 6;
	localparam int IN_DIST_W  = 16;
	localparam int CFG_W      = 7;
	localparam int BOUND_W    = 23;
	localparam int DONE_W     = 7;
	localparam int CFG_RESET  = 64;
	localparam int MIN_NODES  = 3;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_STEP  = 2'd2,
		ACT_RUN   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		SWP_NEAR = 2'd0,
		SWP_INIT = 2'd1,
		SWP_UPD  = 2'd2
	} sweep_kind_t;

	typedef struct packed {
		logic        sweep_start;
		sweep_kind_t sweep_kind;
		logic        node_setup;
		logic        commit;
		logic        node_end;
		logic        bound_clear;
		logic        result_load;
		logic        dist_write;
	} cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic tree_done;
		logic node_left;
		logic out_free;
	} status_t;

endpackage

// File: hw/rtl/tsp1t_ram.sv
// ----------------------------------------------------------------------------
// tsp1t_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsp1t_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: hw/rtl/tsp1t_dp.sv
// ----------------------------------------------------------------------------
// tsp1t_dp: datapath of the 1-tree lower bound block
// Distance and attach-cost memories, sweep engine, Prim bookkeeping, bound
// and result register.
// ----------------------------------------------------------------------------
module tsp1t_dp #(
	parameter int MAX_NODES = tsp1t_pkg::MAX_NODES_DEF,
	parameter int DIST_BITS = tsp1t_pkg::DIST_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tsp1t_pkg::cmd_t                  cmd,
	output tsp1t_pkg::status_t               st,
	input  logic                             cfg_we,
	input  logic [tsp1t_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [tsp1t_pkg::ROW_W-1:0]      row,
	input  logic [tsp1t_pkg::ROW_W-1:0]      column,
	input  logic [tsp1t_pkg::IN_DIST_W-1:0]  distance,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tsp1t_pkg::BOUND_W-1:0]    bound,
	output logic [tsp1t_pkg::DONE_W-1:0]     nodes_done,
	output logic                             finished
);

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int AW    = $clog2(MAX_NODES * MAX_NODES);
	localparam int SUM_W = DIST_BITS + IDX_W + 1;
	localparam int TOT_W = (SUM_W + 2 > tsp1t_pkg::BOUND_W + 1) ?
		SUM_W + 2 : tsp1t_pkg::BOUND_W + 1;
	localparam logic [TOT_W-1:0] BOUND_MAX = TOT_W'((64'd1 << tsp1t_pkg::BOUND_W) - 64'd1);

	logic [tsp1t_pkg::CFG_W-1:0] node_count_q;
	logic [CNT_W-1:0]            n;

	logic [CNT_W-1:0]            next_node_q;
	logic [tsp1t_pkg::BOUND_W-1:0] bound_q;
	logic [SUM_W-1:0]            tree_sum_q;
	logic [CNT_W-1:0]            picks_q;
	logic [IDX_W-1:0]            cur_q;
	logic [IDX_W-1:0]            pick_q;
	logic                        pick_ok_q;
	logic [DIST_BITS-1:0]        best_q;
	logic [DIST_BITS-1:0]        first_q;
	logic [DIST_BITS-1:0]        second_q;
	logic [1:0]                  seen_q;

	logic                        sweep_act_q;
	tsp1t_pkg::sweep_kind_t      kind_q;
	logic [CNT_W-1:0]            idx_q;
	logic                        v_s1;
	logic                        elig_s1;
	logic [IDX_W-1:0]            i_s1;

	logic [IDX_W-1:0]            k;
	logic [IDX_W-1:0]            i_cur;
	logic                        issue;
	logic                        elig;
	logic [IDX_W-1:0]            ea;
	logic [IDX_W-1:0]            eb;
	logic                        wr_ok;
	logic [AW-1:0]               dist_wr_addr;
	logic [AW-1:0]               dist_rd_addr;
	logic [DIST_BITS-1:0]        dist_rd;
	logic [DIST_BITS:0]          att_rd;
	logic [DIST_BITS-1:0]        att_new;
	logic                        cand_s1;
	logic                        att_we;
	logic [IDX_W-1:0]            att_waddr;
	logic [DIST_BITS:0]          att_wdata;
	logic [TOT_W-1:0]            total;
	logic [tsp1t_pkg::BOUND_W-1:0] total_sat;

	// clamp the node count to the supported range
	always_comb begin
		if (32'(node_count_q) < tsp1t_pkg::MIN_NODES) begin
			n = CNT_W'(tsp1t_pkg::MIN_NODES);
		end else if (32'(node_count_q) > MAX_NODES) begin
			n = CNT_W'(MAX_NODES);
		end else begin
			n = CNT_W'(node_count_q);
		end
	end

	assign k     = next_node_q[IDX_W-1:0];
	assign i_cur = idx_q[IDX_W-1:0];
	assign issue = sweep_act_q && (idx_q < n);
	assign elig  = (i_cur != k);

	always_comb begin
		if (kind_q == tsp1t_pkg::SWP_NEAR) begin
			ea = k;
			eb = i_cur;
		end else begin
			ea = (cur_q < i_cur) ? cur_q : i_cur;
			eb = (cur_q < i_cur) ? i_cur : cur_q;
		end
	end

	assign wr_ok        = (32'(row) < MAX_NODES) && (32'(column) < MAX_NODES);
	assign dist_wr_addr = AW'(32'(row)) * AW'(MAX_NODES) + AW'(32'(column));
	assign dist_rd_addr = AW'(ea) * AW'(MAX_NODES) + AW'(eb);

	tsp1t_ram #(
		.WIDTH (DIST_BITS),
		.DEPTH (MAX_NODES * MAX_NODES)
	) u_dist_ram (
		.clk     (clk),
		.wr_en   (cmd.dist_write && wr_ok),
		.wr_addr (dist_wr_addr),
		.wr_data (DIST_BITS'(32'(distance))),
		.rd_addr (dist_rd_addr),
		.rd_data (dist_rd)
	);

	always_comb begin
		if (kind_q == tsp1t_pkg::SWP_UPD && att_rd[DIST_BITS-1:0] < dist_rd) begin
			att_new = att_rd[DIST_BITS-1:0];
		end else begin
			att_new = dist_rd;
		end
	end

	// candidate: every sweep leaves out node k; the init sweep takes every other
	// node but the root, update sweeps the nodes whose joined flag is still clear
	always_comb begin
		if (!v_s1 || !elig_s1) begin
			cand_s1 = 1'b0;
		end else if (kind_q == tsp1t_pkg::SWP_INIT) begin
			cand_s1 = (i_s1 != cur_q);
		end else if (kind_q == tsp1t_pkg::SWP_UPD) begin
			cand_s1 = !att_rd[DIST_BITS];
		end else begin
			cand_s1 = 1'b1;
		end
	end

	// attach memory: top bit marks a node joined to the tree; the init sweep
	// rewrites every entry but the skipped node's, a commit sets the flag of the picked node
	assign att_we = cmd.commit ||
		(v_s1 && elig_s1 && (kind_q == tsp1t_pkg::SWP_INIT)) ||
		(cand_s1 && (kind_q == tsp1t_pkg::SWP_UPD));
	assign att_waddr = cmd.commit ? pick_q : i_s1;
	assign att_wdata = cmd.commit ? {1'b1, best_q} :
		{(kind_q == tsp1t_pkg::SWP_INIT) && (i_s1 == cur_q), att_new};

	tsp1t_ram #(
		.WIDTH (DIST_BITS + 1),
		.DEPTH (MAX_NODES)
	) u_attach_ram (
		.clk     (clk),
		.wr_en   (att_we),
		.wr_addr (att_waddr),
		.wr_data (att_wdata),
		.rd_addr (i_cur),
		.rd_data (att_rd)
	);

	assign total = TOT_W'(tree_sum_q) + TOT_W'(first_q) + TOT_W'(second_q);
	assign total_sat = (total > BOUND_MAX) ? tsp1t_pkg::BOUND_W'(BOUND_MAX) :
		tsp1t_pkg::BOUND_W'(total);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= tsp1t_pkg::CFG_W'(tsp1t_pkg::CFG_RESET);
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// sweep engine: issue one index per cycle, finish it in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_act_q <= 1'b0;
			kind_q      <= tsp1t_pkg::SWP_NEAR;
			idx_q       <= '0;
			v_s1        <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (cmd.sweep_start) begin
				sweep_act_q <= 1'b1;
				kind_q      <= cmd.sweep_kind;
				idx_q       <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end else begin
				sweep_act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		elig_s1 <= elig;
		i_s1    <= i_cur;
	end

	// Prim and nearest-pair bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_node_q <= '0;
			bound_q     <= '0;
			tree_sum_q  <= '0;
			picks_q     <= '0;
			pick_ok_q   <= 1'b0;
			seen_q      <= '0;
		end else begin
			if (cmd.bound_clear) begin
				next_node_q <= '0;
				bound_q     <= '0;
			end
			if (cmd.node_setup) begin
				tree_sum_q              <= '0;
				picks_q                 <= '0;
				seen_q                  <= '0;
			end
			if (cmd.sweep_start) begin
				pick_ok_q <= 1'b0;
			end
			if (cand_s1) begin
				if (kind_q == tsp1t_pkg::SWP_NEAR) begin
					if (seen_q == 2'd0) begin
						seen_q <= 2'd1;
					end else begin
						seen_q <= 2'd2;
					end
				end else if (!pick_ok_q || att_new < best_q) begin
					pick_ok_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				tree_sum_q        <= tree_sum_q + SUM_W'(best_q);
				picks_q           <= picks_q + CNT_W'(1);
				pick_ok_q         <= 1'b0;
			end
			if (cmd.node_end) begin
				next_node_q <= next_node_q + CNT_W'(1);
				if (total_sat > bound_q) begin
					bound_q <= total_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.node_setup) begin
			cur_q <= (k == '0) ? IDX_W'(1) : IDX_W'(0);
		end else if (cmd.commit) begin
			cur_q <= pick_q;
		end
		if (cand_s1) begin
			if (kind_q == tsp1t_pkg::SWP_NEAR) begin
				if (seen_q == 2'd0) begin
					first_q <= dist_rd;
				end else if (dist_rd < first_q) begin
					second_q <= first_q;
					first_q  <= dist_rd;
				end else if (seen_q == 2'd1 || dist_rd < second_q) begin
					second_q <= dist_rd;
				end
			end else if (!pick_ok_q || att_new < best_q) begin
				pick_q <= i_s1;
				best_q <= att_new;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			bound      <= bound_q;
			nodes_done <= tsp1t_pkg::DONE_W'(next_node_q);
			finished   <= (next_node_q >= n);
		end
	end

	assign st.sweep_done = !sweep_act_q && !v_s1;
	assign st.tree_done  = ((CNT_W + 1)'(picks_q) + (CNT_W + 1)'(2)) == (CNT_W + 1)'(n);
	assign st.node_left  = (next_node_q < n);
	assign st.out_free   = !out_valid || out_ready;

	a_commit_has_pick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> pick_ok_q)
		else $error("tree commit without a candidate");

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> !out_valid)
		else $error("result loaded over a pending result");

	a_idx_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= CNT_W'(MAX_NODES))
		else $error("sweep index ran past the matrix");

	a_commit_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !sweep_act_q && !v_s1)
		else $error("commit while a sweep is in flight");

endmodule

// File: hw/rtl/tsp1t_ctrl.sv
// ----------------------------------------------------------------------------
// tsp1t_ctrl: controller of the 1-tree lower bound block
// Sequences the nearest-pair sweep, Prim sweeps and result hand-off.
// ----------------------------------------------------------------------------
module tsp1t_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tsp1t_pkg::ACTION_W-1:0] action,
	input  tsp1t_pkg::status_t             st,
	output tsp1t_pkg::cmd_t                cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_NEAR   = 7'b0000010,
		ST_TREE   = 7'b0000100,
		ST_COMMIT = 7'b0001000,
		ST_CHECK  = 7'b0010000,
		ST_NEXT   = 7'b0100000,
		ST_RESULT = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   run_all_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE) && st.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd            = '0;
		cmd.sweep_kind = tsp1t_pkg::SWP_NEAR;
		state_nxt      = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action)
						tsp1t_pkg::ACT_WRITE: begin
							cmd.dist_write = 1'b1;
						end
						tsp1t_pkg::ACT_CLEAR: begin
							cmd.bound_clear = 1'b1;
							state_nxt       = ST_RESULT;
						end
						default: begin
							if (st.node_left) begin
								cmd.node_setup  = 1'b1;
								cmd.sweep_start = 1'b1;
								state_nxt       = ST_NEAR;
							end else begin
								state_nxt = ST_RESULT;
							end
						end
					endcase
				end
			end
			ST_NEAR: begin
				if (st.sweep_done) begin
					cmd.sweep_start = 1'b1;
					cmd.sweep_kind  = tsp1t_pkg::SWP_INIT;
					state_nxt       = ST_TREE;
				end
			end
			ST_TREE: begin
				if (st.sweep_done) begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = ST_CHECK;
			end
			ST_CHECK: begin
				if (st.tree_done) begin
					cmd.node_end = 1'b1;
					state_nxt    = ST_NEXT;
				end else begin
					cmd.sweep_start = 1'b1;
					cmd.sweep_kind  = tsp1t_pkg::SWP_UPD;
					state_nxt       = ST_TREE;
				end
			end
			ST_NEXT: begin
				if (run_all_q && st.node_left) begin
					cmd.node_setup  = 1'b1;
					cmd.sweep_start = 1'b1;
					state_nxt       = ST_NEAR;
				end else begin
					state_nxt = ST_RESULT;
				end
			end
			ST_RESULT: begin
				cmd.result_load = 1'b1;
				state_nxt       = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			run_all_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				run_all_q <= (action == tsp1t_pkg::ACT_RUN);
			end
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state lost its one-hot code");

	a_result_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |=> state_q == ST_IDLE)
		else $error("result load did not return to idle");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == ST_IDLE)
		else $error("transfer taken while busy");

endmodule

// File: hw/rtl/tsp_one_tree_lower_bound.sv
// ----------------------------------------------------------------------------
// tsp_one_tree_lower_bound: 1-tree lower bound for the travelling salesman
// Loads a distance matrix, then for each skipped node forms the MST weight
// over the other nodes plus its two nearest distances, keeping the maximum.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  input    | in_valid / in_ready   | action, row, column, distance
//  result   | out_valid / out_ready | bound, nodes_done, finished
//  config   | cfg_we                | cfg_wdata (node_count)
//
//  A node step runs a nearest-pair sweep, then n-2 Prim sweeps; each sweep makes
//  n matrix reads at one per cycle from the single read port, then drains, and
//  each Prim sweep is followed by a commit and a check.
//  Reset clears progress and bound and sets the node count to 64; the matrix
//  is not cleared.
//  Input stalls while a node is in work or while a result waits untaken.
// ----------------------------------------------------------------------------
module tsp_one_tree_lower_bound #(
	parameter int MAX_NODES = tsp1t_pkg::MAX_NODES_DEF,
	parameter int DIST_BITS = tsp1t_pkg::DIST_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tsp1t_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tsp1t_pkg::ACTION_W-1:0]   action,
	input  logic [tsp1t_pkg::ROW_W-1:0]      row,
	input  logic [tsp1t_pkg::ROW_W-1:0]      column,
	input  logic [tsp1t_pkg::IN_DIST_W-1:0]  distance,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tsp1t_pkg::BOUND_W-1:0]    bound,
	output logic [tsp1t_pkg::DONE_W-1:0]     nodes_done,
	output logic                             finished
);

	// commands from the sequencer, status back from the datapath
	tsp1t_pkg::cmd_t    cmd;
	tsp1t_pkg::status_t st;

	tsp1t_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.st       (st),
		.cmd      (cmd)
	);

	// hold matrix, scratch and bound; drive the result register
	tsp1t_dp #(
		.MAX_NODES (MAX_NODES),
		.DIST_BITS (DIST_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.row        (row),
		.column     (column),
		.distance   (distance),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bound      (bound),
		.nodes_done (nodes_done),
		.finished   (finished)
	);

endmodule

// File: tb/sv/tsp1t_bound_checker.sv
// ----------------------------------------------------------------------------
// tsp1t_bound_checker: result predictor and comparator for the 1-tree block
// Watches the config, input and result channels, predicts the bound,
// nodes_done and finished of every result, and counts mismatches.
// ----------------------------------------------------------------------------
module tsp1t_bound_checker
	import tsp1t_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [ACTION_W-1:0]  action,
	input  logic [ROW_W-1:0]     row,
	input  logic [ROW_W-1:0]     column,
	input  logic [IN_DIST_W-1:0] distance,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [BOUND_W-1:0]   bound,
	input  logic [DONE_W-1:0]    nodes_done,
	input  logic                 finished,
	output int                   mismatches,
	output int                   bounds_pending,
	output int                   bounds_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = MAX_NODES_DEF;
	localparam longint unsigned BOUND_CAP = (64'd1 << BOUND_W) - 1;

	typedef struct {
		logic [BOUND_W-1:0] bound;
		logic [DONE_W-1:0]  nodes_done;
		logic               finished;
	} bound_report_t;

	logic [IN_DIST_W-1:0] dist_mem [0:NODES-1][0:NODES-1];
	logic [CFG_W-1:0]     city_count;
	int                   next_city;
	logic [BOUND_W-1:0]   best_bound;
	bound_report_t        report_q[$];

	function automatic int cities_in_use();
		int n;
		n = int'(city_count);
		if (n < MIN_NODES)
			n = MIN_NODES;
		if (n > NODES)
			n = NODES;
		return n;
	endfunction

	function automatic longint unsigned edge_cost(int a, int b);
		return (a < b) ? longint'(dist_mem[a][b]) : longint'(dist_mem[b][a]);
	endfunction

	// Prim tree over all cities but the skipped one, plus its two nearest.
	function automatic longint unsigned one_tree_weight(int n, int skip);
		bit              joined [NODES];
		longint unsigned attach [NODES];
		longint unsigned sum, cheapest, w, first, second;
		int              root, pick, seen;
		sum = 0;
		root = (skip == 0) ? 1 : 0;
		foreach (joined[i])
			joined[i] = 0;
		joined[root] = 1;
		for (int i = 0; i < n; i++)
			if (i != skip && i != root)
				attach[i] = edge_cost(root, i);
		for (int added = 1; added < n - 1; added++) begin
			pick = -1;
			cheapest = 0;
			for (int i = 0; i < n; i++) begin
				if (i == skip || joined[i])
					continue;
				if (pick < 0 || attach[i] < cheapest) begin
					pick = i;
					cheapest = attach[i];
				end
			end
			if (pick < 0)
				break;
			joined[pick] = 1;
			sum += cheapest;
			for (int i = 0; i < n; i++) begin
				if (i == skip || joined[i])
					continue;
				w = edge_cost(pick, i);
				if (w < attach[i])
					attach[i] = w;
			end
		end
		first = 0;
		second = 0;
		seen = 0;
		for (int i = 0; i < n; i++) begin
			if (i == skip)
				continue;
			w = longint'(dist_mem[skip][i]);
			if (seen == 0 || w < first) begin
				second = first;
				first = w;
			end else if (seen == 1 || w < second) begin
				second = w;
			end
			seen++;
		end
		return sum + first + second;
	endfunction

	function automatic void advance_city(int n);
		longint unsigned total;
		if (next_city >= n)
			return;
		total = one_tree_weight(n, next_city);
		if (total > BOUND_CAP)
			total = BOUND_CAP;
		if (total > longint'(best_bound))
			best_bound = total[BOUND_W-1:0];
		next_city++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bound_report_t want;
		int            n;
		if (!arst_n) begin
			city_count = CFG_W'(CFG_RESET);
			next_city = 0;
			best_bound = '0;
			report_q.delete();
			mismatches = 0;
			bounds_checked = 0;
			bounds_pending = 0;
		end else begin
			if (cfg_we)
				city_count = cfg_wdata;
			if (in_valid && in_ready) begin
				n = cities_in_use();
				case (action_t'(action))
					ACT_WRITE: dist_mem[row][column] = distance;
					ACT_CLEAR: begin
						next_city = 0;
						best_bound = '0;
					end
					ACT_STEP: advance_city(n);
					ACT_RUN: while (next_city < n) advance_city(n);
					default: ;
				endcase
				if (action_t'(action) != ACT_WRITE) begin
					want.bound = best_bound;
					want.nodes_done = DONE_W'(next_city);
					want.finished = (next_city >= n);
					report_q.push_back(want);
				end
			end
			if (out_valid && out_ready) begin
				if (report_q.size() == 0) begin
					$error("result with nothing expected: bound %0d", bound);
					mismatches++;
				end else begin
					want = report_q.pop_front();
					if (bound !== want.bound) begin
						$error("bound: expected %0d, actual %0d", want.bound, bound);
						mismatches++;
					end
					if (nodes_done !== want.nodes_done) begin
						$error("nodes_done: expected %0d, actual %0d",
							want.nodes_done, nodes_done);
						mismatches++;
					end
					if (finished !== want.finished) begin
						$error("finished: expected %0d, actual %0d",
							want.finished, finished);
						mismatches++;
					end
				end
				bounds_checked++;
			end
			bounds_pending = report_q.size();
		end
	end

endmodule

// File: tb/sv/tb_tsp_one_tree_lower_bound.sv
// ----------------------------------------------------------------------------
// tb_tsp_one_tree_lower_bound: stimulus and verdict for the 1-tree block
// Fills the used corner of the distance matrix, runs a directed pass, then
// random phases under several city counts with random gaps and stalls on
// both channels.
// ----------------------------------------------------------------------------
module tb_tsp_one_tree_lower_bound;
	import tsp1t_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Largest city count used; only this corner of the matrix is ever read.
	localparam int FILL_NODES = 20;
	// A full run at 20 cities is a long quiet stretch; leave wide margin.
	localparam int QUIET_LIMIT = 100000;
	localparam int SETTLE_CYCLES = 20;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic [ACTION_W-1:0]  action;
	logic [ROW_W-1:0]     row;
	logic [ROW_W-1:0]     column;
	logic [IN_DIST_W-1:0] distance;
	logic                 out_valid;
	logic                 out_ready;
	logic [BOUND_W-1:0]   bound;
	logic [DONE_W-1:0]    nodes_done;
	logic                 finished;

	int mismatches;
	int bounds_pending;
	int bounds_checked;
	int quiet_cycles;
	int items_sent;
	int city_steps;
	bit big_run_used;

	tsp_one_tree_lower_bound DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.row        (row),
		.column     (column),
		.distance   (distance),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bound      (bound),
		.nodes_done (nodes_done),
		.finished   (finished)
	);

	tsp1t_bound_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.row            (row),
		.column         (column),
		.distance       (distance),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.bound          (bound),
		.nodes_done     (nodes_done),
		.finished       (finished),
		.mismatches     (mismatches),
		.bounds_pending (bounds_pending),
		.bounds_checked (bounds_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: any transfer on either channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: short stalls, a few long ones, burst stretches with no
	// stall, and one long hold-off once some results have gone through so
	// the block backs up and stalls its input.
	initial begin
		int  hold;
		int  burst;
		bit  squeezed;
		int  r;
		hold = 0;
		burst = 0;
		squeezed = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (!squeezed && bounds_checked >= 30) begin
				squeezed = 1;
				hold = 800;
				out_ready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					out_ready <= 1'b1;
				end else if (r < 90) begin
					hold = $urandom_range(1, 3);
					out_ready <= 1'b0;
				end else if (r < 95) begin
					hold = $urandom_range(20, 80);
					out_ready <= 1'b0;
				end else begin
					burst = $urandom_range(50, 300);
					out_ready <= 1'b1;
				end
			end
		end
	end

	// Offer one transfer and hold it until taken, then maybe drop valid for
	// a gap. The next call raises valid again at a later edge only.
	task automatic send_item(action_t act, logic [ROW_W-1:0] r,
			logic [ROW_W-1:0] c, logic [IN_DIST_W-1:0] d, bit busy_lane);
		int pick;
		int gap;
		in_valid <= 1'b1;
		action <= act;
		row <= r;
		column <= c;
		distance <= d;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		if (act == ACT_STEP || act == ACT_RUN)
			city_steps++;
		pick = $urandom_range(0, 99);
		if (busy_lane && pick < 95)
			gap = 0;
		else if (pick < 50)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drain every expected result, then let any write still in flight land.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bounds_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_city_count(logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Distances: half tiny so that ties are common, the rest up to full range.
	function automatic logic [IN_DIST_W-1:0] rand_distance();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return IN_DIST_W'($urandom_range(0, 7));
		else if (pick < 60)
			return {IN_DIST_W{1'b1}};
		else
			return IN_DIST_W'($urandom);
	endfunction

	task automatic random_phase(logic [CFG_W-1:0] count, int items);
		int      pick;
		bit      wide;
		action_t act;
		wide = (count > 16);
		set_city_count(count);
		for (int i = 0; i < items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				act = ACT_WRITE;
			end else if (pick < 72) begin
				act = ACT_CLEAR;
			end else if (!wide) begin
				act = (pick < 88) ? ACT_STEP : ACT_RUN;
			end else if (pick < 80) begin
				act = ACT_STEP;
			end else if (pick < 82 && !big_run_used) begin
				// Only one full run at the largest size: it is very long.
				big_run_used = 1;
				act = ACT_RUN;
			end else begin
				act = ACT_WRITE;
			end
			send_item(act, ROW_W'($urandom_range(0, FILL_NODES - 1)),
				ROW_W'($urandom_range(0, FILL_NODES - 1)), rand_distance(), 1'b0);
		end
		wait_drained();
	endtask

	initial begin
		logic [CFG_W-1:0] counts [11];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		action = ACT_WRITE;
		row = '0;
		column = '0;
		distance = '0;
		quiet_cycles = 0;
		items_sent = 0;
		city_steps = 0;
		big_run_used = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the used corner first so no step ever reads an unset entry.
		for (int r = 0; r < FILL_NODES; r++)
			for (int c = 0; c < FILL_NODES; c++)
				send_item(ACT_WRITE, ROW_W'(r), ROW_W'(c), rand_distance(), 1'b1);
		wait_drained();

		// Directed pass at the smallest size.
		set_city_count(CFG_W'(MIN_NODES));
		send_item(ACT_WRITE, 6'd0, 6'd1, 16'd0, 1'b0);
		send_item(ACT_WRITE, 6'd0, 6'd2, 16'hFFFF, 1'b0);
		send_item(ACT_WRITE, 6'd1, 6'd2, 16'hFFFF, 1'b0);
		send_item(ACT_WRITE, 6'd1, 6'd0, 16'hFFFF, 1'b0);
		send_item(ACT_WRITE, 6'd2, 6'd0, 16'hFFFF, 1'b0);
		send_item(ACT_WRITE, 6'd2, 6'd1, 16'hFFFF, 1'b0);
		send_item(ACT_WRITE, 6'd63, 6'd63, 16'hFFFF, 1'b0);
		send_item(ACT_WRITE, 6'd63, 6'd0, 16'd0, 1'b0);
		send_item(ACT_CLEAR, 6'd63, 6'd63, 16'hFFFF, 1'b0);
		send_item(ACT_STEP, 6'd0, 6'd0, 16'd0, 1'b0);
		send_item(ACT_STEP, 6'd0, 6'd0, 16'd0, 1'b0);
		send_item(ACT_RUN, 6'd0, 6'd0, 16'd0, 1'b0);
		// Steps and runs once finished leave the bound alone.
		send_item(ACT_STEP, 6'd0, 6'd0, 16'd0, 1'b0);
		send_item(ACT_RUN, 6'd0, 6'd0, 16'd0, 1'b0);
		// Equal weights in the upper triangle: the tree must still be a true minimum.
		send_item(ACT_WRITE, 6'd0, 6'd1, 16'd5, 1'b0);
		send_item(ACT_WRITE, 6'd0, 6'd2, 16'd5, 1'b0);
		send_item(ACT_WRITE, 6'd1, 6'd2, 16'd5, 1'b0);
		send_item(ACT_CLEAR, 6'd0, 6'd0, 16'd0, 1'b0);
		send_item(ACT_RUN, 6'd0, 6'd0, 16'd0, 1'b0);
		wait_drained();

		// Random phases: counts below the minimum clamp; lowering the count
		// below progress reads as finished.
		counts = '{7'd8, 7'd0, 7'd5, 7'd20, 7'd2, 7'd6, 7'd16, 7'd1, 7'd12,
			7'd4, 7'd3};
		foreach (counts[p])
			random_phase(counts[p], 55);

		$display("covered %0d transfers in, %0d node steps or runs, %0d bounds checked",
			items_sent, city_steps, bounds_checked);
		$display("city counts swept from 0 to 20 with clamping at the low end");
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
